/* hdl/dmds_pkg.sv */
// ----------------------------------------------------------------------------
// dmds_pkg: shared types and constants for the DC motor drive sequencer
// Payload structs for the request, response and register write channels,
// command, mode and register codes, and the widths of the serial datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dmds_pkg;

   // Field widths
   localparam int DUTY_BITS  = 16;
   localparam int VOLT_BITS  = 16;
   localparam int TICK_BITS  = 16;
   localparam int FAULT_BITS = 16;
   localparam int CMD_BITS   = 3;
   localparam int MODE_BITS  = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   // Scaling arithmetic: scale = set*100/v stays below 100 when v > set
   localparam int PCT        = 100;
   localparam int ROUND_HALF = 50;
   localparam int SCALE_BITS = 7;
   localparam int NUM_BITS   = VOLT_BITS + SCALE_BITS;
   localparam int PROD_BITS  = DUTY_BITS + SCALE_BITS;
   localparam int DIGIT_BITS = 2;
   localparam int DIV_DIGITS = (PROD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PSH_BITS   = DIV_DIGITS * DIGIT_BITS;
   localparam int REM_BITS   = 7;
   localparam int DT_BITS    = REM_BITS + DIGIT_BITS;
   localparam int STEP_BITS  = $clog2(DIV_DIGITS);

   // Register reset values
   localparam logic [VOLT_BITS-1:0] SET_VOLTAGE_RST = VOLT_BITS'(2400);
   localparam logic [DUTY_BITS-1:0] SEEK_DUTY_RST   = '0;
   localparam logic [TICK_BITS-1:0] COAST_TICKS_RST = TICK_BITS'(10);

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SET_VOLTAGE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEEK_DUTY   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COAST_TICKS = 2'd2;

   // Motor commands
   localparam logic [CMD_BITS-1:0] CMD_IDLE     = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_SEEK_MIN = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_SEEK_MID = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_SEEK_MAX = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_CW       = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_CCW      = 3'd5;

   // Motor modes
   localparam logic [MODE_BITS-1:0] MODE_RUN   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_COAST = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_BRAKE = 2'd2;

   // Item function
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_COMMAND = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [CMD_BITS-1:0]   command;
      logic [DUTY_BITS-1:0]  duty_request;
      logic [VOLT_BITS-1:0]  supply_voltage;
      logic                  limit_min_n;
      logic                  limit_mid_n;
      logic                  limit_max_n;
      logic                  fault_n;
   } req_payload_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0]  duty_out;
      logic                  phase_out;
      logic                  decay_out;
      logic                  reset_pulse;
      logic                  done_res;
      logic [FAULT_BITS-1:0] fault_total;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_BITS-1:0]  reg_index;
      logic [CSR_DATA_BITS-1:0] wr_data;
   } csr_payload_type;

endpackage

`default_nettype wire

/* hdl/dmds_stream_if.sv */
// ----------------------------------------------------------------------------
// dmds_stream_if: valid/ready channel
// Carries one payload beat per handshake; the source drives valid and data,
// the sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmds_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/dc_motor_drive_sequencer.sv */
// Sequence: a request beat goes to the finish state; a scaled duty first
//   takes 7 radix-2 steps of the scale divider and duty multiplier, then
//   12 radix-4 steps dividing by 100. The finish state loads the response
//   register once it is free.
// Flow: one item at a time; a new request is taken only in the idle state,
//   reached once the finish state has found the response register free.
// Reset: registers take their reset values, motor braking, counters at zero.
// ----------------------------------------------------------------------------
// dc_motor_drive_sequencer: DC motor drive sequencer
// Runs, seeks and stops a brushed motor driver, with coast-then-brake stop,
// supply voltage duty scaling computed digit-serially, and fault counting.
// ----------------------------------------------------------------------------
`default_nettype none

module dc_motor_drive_sequencer (
   input  wire logic   clock,
   input  wire logic   reset,
   dmds_stream_if.sink   req_if,
   dmds_stream_if.source rsp_if,
   dmds_stream_if.sink   csr_if
);
   import dmds_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCALE = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   // Control state
   logic [1:0]            state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Registers
   logic [VOLT_BITS-1:0]  set_voltage_ff, set_voltage_in;
   logic [DUTY_BITS-1:0]  seek_duty_ff, seek_duty_in;
   logic [TICK_BITS-1:0]  coast_ticks_ff, coast_ticks_in;

   // Motor state
   logic [MODE_BITS-1:0]  mode_ff, mode_in;
   logic [TICK_BITS-1:0]  coast_timer_ff, coast_timer_in;
   logic [FAULT_BITS-1:0] fault_count_ff, fault_count_in;
   logic [DUTY_BITS-1:0]  duty_ff, duty_in;
   logic                  phase_ff, phase_in;
   logic                  decay_ff, decay_in;
   logic                  pulse_ff, pulse_in;
   logic                  done_ff, done_in;

   // Serial datapath
   logic [VOLT_BITS-1:0]  divisor_ff, divisor_in;
   logic [DUTY_BITS-1:0]  mcand_ff, mcand_in;
   logic [VOLT_BITS-1:0]  srem_ff, srem_in;
   logic [SCALE_BITS-1:0] nlow_ff, nlow_in;
   logic [PROD_BITS-1:0]  acc_ff, acc_in;
   logic [PSH_BITS-1:0]   psh_ff, psh_in;
   logic [REM_BITS-1:0]   drem_ff, drem_in;
   logic [DUTY_BITS-1:0]  quot_ff, quot_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   // Decode and step signals
   logic                  req_fire;
   logic                  csr_fire;
   logic                  out_free;
   req_payload_type       req;
   logic                  is_seek, is_run, reached, do_drive, need_scale;
   logic [DUTY_BITS-1:0]  duty_sel;
   logic [MODE_BITS-1:0]  stop_mode;
   logic                  stop_decay;
   logic [TICK_BITS-1:0]  stop_timer;
   logic [NUM_BITS-1:0]   num;
   logic [VOLT_BITS:0]    strial;
   logic                  sge;
   logic [VOLT_BITS:0]    srem_next;
   logic [PROD_BITS-1:0]  acc_next;
   logic [DT_BITS-1:0]    dtrial;
   logic [DIGIT_BITS-1:0] digit;
   logic [REM_BITS-1:0]   drem_next;
   logic [DUTY_BITS-1:0]  quot_next;

   // Handshakes
   assign req      = req_if.data;
   assign req_fire = req_if.valid && req_if.ready;
   assign csr_fire = csr_if.valid && csr_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // Decode the command beat
   always_comb begin
      is_seek = 1'b0;
      is_run  = 1'b0;
      reached = 1'b0;
      case (req.command)
         CMD_SEEK_MIN: begin
            is_seek = 1'b1;
            reached = !req.limit_min_n;
         end
         CMD_SEEK_MID: begin
            is_seek = 1'b1;
            reached = !req.limit_mid_n;
         end
         CMD_SEEK_MAX: begin
            is_seek = 1'b1;
            reached = !req.limit_max_n;
         end
         CMD_CW, CMD_CCW: begin
            is_run = 1'b1;
         end
         default: begin
            is_run = 1'b0;
         end
      endcase
      do_drive   = is_run || (is_seek && !reached);
      duty_sel   = is_run ? req.duty_request : seek_duty_ff;
      need_scale = (req.supply_voltage > set_voltage_ff);
   end

   // Stop: running goes to coasting, coasting brakes once the timer is up
   always_comb begin
      if (mode_ff == MODE_RUN) begin
         stop_mode  = MODE_COAST;
         stop_decay = 1'b1;
         stop_timer = '0;
      end else begin
         stop_mode  = mode_ff;
         stop_decay = decay_ff;
         stop_timer = coast_timer_ff;
      end
      if (!(stop_mode == MODE_COAST && stop_timer < coast_ticks_ff)) begin
         stop_mode  = MODE_BRAKE;
         stop_decay = 1'b0;
      end
   end

   // Scale step: one quotient bit of set*100/v, fed straight into the
   // MSB-first shift-add multiply of the duty
   assign num       = NUM_BITS'(NUM_BITS'(set_voltage_ff) * NUM_BITS'(PCT));
   assign strial    = {srem_ff, nlow_ff[SCALE_BITS-1]};
   assign sge       = (strial >= {1'b0, divisor_ff});
   assign srem_next = sge ? (strial - {1'b0, divisor_ff}) : strial;
   assign acc_next  = {acc_ff[PROD_BITS-2:0], 1'b0}
                    + (sge ? PROD_BITS'(mcand_ff) : PROD_BITS'(0));

   // Divide step: one radix-4 digit of product/100
   assign dtrial = {drem_ff, psh_ff[PSH_BITS-1 -: DIGIT_BITS]};
   always_comb begin
      if (dtrial >= DT_BITS'(3 * PCT)) begin
         digit     = DIGIT_BITS'(3);
         drem_next = REM_BITS'(dtrial - DT_BITS'(3 * PCT));
      end else if (dtrial >= DT_BITS'(2 * PCT)) begin
         digit     = DIGIT_BITS'(2);
         drem_next = REM_BITS'(dtrial - DT_BITS'(2 * PCT));
      end else if (dtrial >= DT_BITS'(PCT)) begin
         digit     = DIGIT_BITS'(1);
         drem_next = REM_BITS'(dtrial - DT_BITS'(PCT));
      end else begin
         digit     = DIGIT_BITS'(0);
         drem_next = REM_BITS'(dtrial);
      end
   end
   assign quot_next = {quot_ff[DUTY_BITS-DIGIT_BITS-1:0], digit};

   // Next state
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      set_voltage_in = set_voltage_ff;
      seek_duty_in   = seek_duty_ff;
      coast_ticks_in = coast_ticks_ff;
      mode_in        = mode_ff;
      coast_timer_in = coast_timer_ff;
      fault_count_in = fault_count_ff;
      duty_in        = duty_ff;
      phase_in       = phase_ff;
      decay_in       = decay_ff;
      pulse_in       = pulse_ff;
      done_in        = done_ff;
      divisor_in     = divisor_ff;
      mcand_in       = mcand_ff;
      srem_in        = srem_ff;
      nlow_in        = nlow_ff;
      acc_in         = acc_ff;
      psh_in         = psh_ff;
      drem_in        = drem_ff;
      quot_in        = quot_ff;
      rsp_data_in    = rsp_data_ff;

      // Take register writes
      if (csr_fire) begin
         case (csr_if.data.reg_index)
            CSR_SET_VOLTAGE: set_voltage_in = VOLT_BITS'(csr_if.data.wr_data);
            CSR_SEEK_DUTY:   seek_duty_in   = DUTY_BITS'(csr_if.data.wr_data);
            CSR_COAST_TICKS: coast_ticks_in = TICK_BITS'(csr_if.data.wr_data);
            default: begin
               set_voltage_in = set_voltage_ff;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pulse_in = 1'b0;
               done_in  = 1'b0;
               state_in = ST_FIN;
               if (req.func == FUNC_TICK) begin
                  // Advance the coast timer, saturating
                  if (coast_timer_ff != '1) begin
                     coast_timer_in = coast_timer_ff + TICK_BITS'(1);
                  end
               end else if (do_drive) begin
                  phase_in = (req.command != CMD_CCW);
                  decay_in = 1'b0;
                  if (duty_sel == '0) begin
                     duty_in = '0;
                  end else begin
                     mode_in = MODE_RUN;
                     if (!req.fault_n) begin
                        fault_count_in = fault_count_ff + FAULT_BITS'(1);
                        pulse_in       = 1'b1;
                     end
                     if (need_scale) begin
                        // Load the serial divider and multiplier
                        divisor_in = req.supply_voltage;
                        mcand_in   = duty_sel;
                        srem_in    = num[NUM_BITS-1:SCALE_BITS];
                        nlow_in    = num[SCALE_BITS-1:0];
                        acc_in     = '0;
                        step_in    = '0;
                        state_in   = ST_SCALE;
                     end else begin
                        duty_in = duty_sel;
                     end
                  end
               end else begin
                  duty_in        = '0;
                  mode_in        = stop_mode;
                  decay_in       = stop_decay;
                  coast_timer_in = stop_timer;
                  done_in        = 1'b1;
               end
            end
         end
         ST_SCALE: begin
            srem_in = srem_next[VOLT_BITS-1:0];
            nlow_in = {nlow_ff[SCALE_BITS-2:0], 1'b0};
            acc_in  = acc_next;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(SCALE_BITS - 1)) begin
               psh_in   = PSH_BITS'(acc_next);
               drem_in  = '0;
               quot_in  = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            psh_in  = {psh_ff[PSH_BITS-DIGIT_BITS-1:0], DIGIT_BITS'(0)};
            drem_in = drem_next;
            quot_in = quot_next;
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIV_DIGITS - 1)) begin
               // Round up when the remainder is above one half
               duty_in  = quot_next
                        + DUTY_BITS'(drem_next > REM_BITS'(ROUND_HALF));
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.duty_out    = duty_ff;
               rsp_data_in.phase_out   = phase_ff;
               rsp_data_in.decay_out   = decay_ff;
               rsp_data_in.reset_pulse = pulse_ff;
               rsp_data_in.done_res    = done_ff;
               rsp_data_in.fault_total = fault_count_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         set_voltage_ff <= SET_VOLTAGE_RST;
         seek_duty_ff   <= SEEK_DUTY_RST;
         coast_ticks_ff <= COAST_TICKS_RST;
         mode_ff        <= MODE_BRAKE;
         coast_timer_ff <= '0;
         fault_count_ff <= '0;
         duty_ff        <= '0;
         phase_ff       <= 1'b0;
         decay_ff       <= 1'b0;
         pulse_ff       <= 1'b0;
         done_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
         set_voltage_ff <= set_voltage_in;
         seek_duty_ff   <= seek_duty_in;
         coast_ticks_ff <= coast_ticks_in;
         mode_ff        <= mode_in;
         coast_timer_ff <= coast_timer_in;
         fault_count_ff <= fault_count_in;
         duty_ff        <= duty_in;
         phase_ff       <= phase_in;
         decay_ff       <= decay_in;
         pulse_ff       <= pulse_in;
         done_ff        <= done_in;
      end
   end

   // Datapath and output payload registers
   always_ff @(posedge clock) begin
      divisor_ff  <= divisor_in;
      mcand_ff    <= mcand_in;
      srem_ff     <= srem_in;
      nlow_ff     <= nlow_in;
      acc_ff      <= acc_in;
      psh_ff      <= psh_in;
      drem_ff     <= drem_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* tb/sv/tb_dc_motor_drive_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dc_motor_drive_sequencer: self-checking bench for the motor sequencer
// Walks a directed table (reset state, stop and seek cases, scaling rounding),
// runs short back-to-back bursts of faulted runs and of ticks, then random
// commands under several register settings. Every response beat is checked
// against an in-bench model of the driver outputs or a typed expectation.
// ----------------------------------------------------------------------------
module tb_dc_motor_drive_sequencer;
   import dmds_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int ITEMS_PER_SET  = 82;
   localparam int BURST_ITEMS    = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
   } dir_row_type;

   typedef struct {
      logic [VOLT_BITS-1:0] volt;
      logic [DUTY_BITS-1:0] seek;
      logic [TICK_BITS-1:0] coast;
   } csr_set_type;

   logic clock;
   logic reset;

   dmds_stream_if #(.payload_type(req_payload_type)) req_ch ();
   dmds_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();
   dmds_stream_if #(.payload_type(csr_payload_type)) csr_ch ();

   dc_motor_drive_sequencer uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Register copies
   logic [VOLT_BITS-1:0]  set_volt;
   logic [DUTY_BITS-1:0]  seek_duty;
   logic [TICK_BITS-1:0]  coast_ticks;

   // Motor state copies
   logic [MODE_BITS-1:0]  motor_mode;
   logic [TICK_BITS-1:0]  coast_timer;
   logic [FAULT_BITS-1:0] fault_count;
   logic [DUTY_BITS-1:0]  duty_q;
   logic                  phase_q;
   logic                  decay_q;

   rsp_payload_type pending_outputs[$];
   int  mismatches = 0;
   int  quiet = 0;
   int  req_calm = 0;
   int  rsp_calm = 0;
   bit  no_idle = 1'b0;

   // Clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Draw a wait for one beat, with occasional stretches of back-to-back beats
   function automatic int draw_wait(inout int calm_left);
      if (no_idle) return 0;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 40);
      return $urandom_range(0, 13);
   endfunction

   // Duty after supply voltage compensation
   function automatic logic [DUTY_BITS-1:0] scaled_duty(logic [DUTY_BITS-1:0] duty,
                                                        logic [VOLT_BITS-1:0] volt);
      int unsigned scale, prod, quo, rem;
      if (volt <= set_volt) return duty;
      scale = (32'(set_volt) * 32'(PCT)) / 32'(volt);
      prod  = 32'(duty) * scale;
      quo   = prod / 32'(PCT);
      rem   = prod % 32'(PCT);
      if (rem > 32'(ROUND_HALF)) quo++;
      return DUTY_BITS'(quo);
   endfunction

   // Apply one beat to the motor state and return the driver outputs
   function automatic rsp_payload_type advance_motor(req_payload_type it);
      rsp_payload_type o;
      logic seek, run, reached, pulse, done;
      logic [DUTY_BITS-1:0] duty;
      seek = 1'b0;
      run = 1'b0;
      reached = 1'b0;
      pulse = 1'b0;
      done = 1'b0;
      if (it.func == FUNC_TICK) begin
         if (coast_timer != '1) coast_timer++;
      end else begin
         case (it.command)
            CMD_SEEK_MIN: begin
               seek = 1'b1;
               reached = !it.limit_min_n;
            end
            CMD_SEEK_MID: begin
               seek = 1'b1;
               reached = !it.limit_mid_n;
            end
            CMD_SEEK_MAX: begin
               seek = 1'b1;
               reached = !it.limit_max_n;
            end
            CMD_CW, CMD_CCW: run = 1'b1;
            default: ;
         endcase
         if (run || (seek && !reached)) begin
            phase_q = (it.command != CMD_CCW);
            decay_q = 1'b0;
            duty = run ? it.duty_request : seek_duty;
            if (duty == '0) begin
               duty_q = '0;
            end else begin
               if (!it.fault_n) begin
                  fault_count++;
                  pulse = 1'b1;
               end
               duty_q = scaled_duty(duty, it.supply_voltage);
               motor_mode = MODE_RUN;
            end
         end else begin
            // Stop: coast first, brake once the coast time has passed
            duty_q = '0;
            if (motor_mode == MODE_RUN) begin
               decay_q = 1'b1;
               motor_mode = MODE_COAST;
               coast_timer = '0;
            end
            if (!(motor_mode == MODE_COAST && coast_timer < coast_ticks)) begin
               decay_q = 1'b0;
               motor_mode = MODE_BRAKE;
            end
            done = 1'b1;
         end
      end
      o.duty_out    = duty_q;
      o.phase_out   = phase_q;
      o.decay_out   = decay_q;
      o.reset_pulse = pulse;
      o.done_res    = done;
      o.fault_total = fault_count;
      return o;
   endfunction

   function automatic req_payload_type mk_req(logic func, logic [CMD_BITS-1:0] cmd,
                                              logic [DUTY_BITS-1:0] duty,
                                              logic [VOLT_BITS-1:0] volt,
                                              logic lmin, logic lmid, logic lmax,
                                              logic fault_n);
      req_payload_type r;
      r.func = func;
      r.command = cmd;
      r.duty_request = duty;
      r.supply_voltage = volt;
      r.limit_min_n = lmin;
      r.limit_mid_n = lmid;
      r.limit_max_n = lmax;
      r.fault_n = fault_n;
      return r;
   endfunction

   function automatic rsp_payload_type mk_rsp(logic [DUTY_BITS-1:0] duty, logic ph,
                                              logic dc, logic pl, logic dn,
                                              logic [FAULT_BITS-1:0] faults);
      rsp_payload_type r;
      r.duty_out = duty;
      r.phase_out = ph;
      r.decay_out = dc;
      r.reset_pulse = pl;
      r.done_res = dn;
      r.fault_total = faults;
      return r;
   endfunction

   // Random command or tick, biased toward the interesting corners
   function automatic req_payload_type random_item();
      req_payload_type r;
      int volt;
      r.func = ($urandom_range(0, 9) < 3) ? FUNC_TICK : FUNC_COMMAND;
      r.command = CMD_BITS'($urandom_range(0, 7));
      case ($urandom_range(0, 4))
         0: r.duty_request = '0;
         1: r.duty_request = '1;
         2: r.duty_request = DUTY_BITS'($urandom_range(1, 300));
         default: r.duty_request = DUTY_BITS'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
         0: volt = 0;
         1: volt = 65535;
         2: volt = $urandom_range(0, set_volt);
         3, 4: begin
            volt = int'(set_volt) + $urandom_range(1, 4000);
            if (volt > 65535) volt = 65535;
         end
         default: volt = $urandom_range(0, 65535);
      endcase
      r.supply_voltage = VOLT_BITS'(volt);
      r.limit_min_n = ($urandom_range(0, 3) != 0);
      r.limit_mid_n = ($urandom_range(0, 3) != 0);
      r.limit_max_n = ($urandom_range(0, 3) != 0);
      r.fault_n = ($urandom_range(0, 7) != 0);
      return r;
   endfunction

   // Offer one request beat; predict at the handshake
   task automatic send_req(input req_payload_type it, input bit typed,
                           input rsp_payload_type want);
      int gap;
      rsp_payload_type predicted;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = advance_motor(it);
      pending_outputs.push_back(typed ? want : predicted);
   endtask

   // Write one register; the block is idle whenever this is called
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= '{reg_index: idx, wr_data: value};
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         CSR_SET_VOLTAGE: set_volt = value;
         CSR_SEEK_DUTY:   seek_duty = value;
         CSR_COAST_TICKS: coast_ticks = value;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and drain every outstanding response
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Response side: random ready, check each beat against the oldest expectation
   initial begin
      int gap;
      rsp_payload_type want, got;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = draw_wait(rsp_calm);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got = rsp_ch.data;
         if (pending_outputs.size() == 0) begin
            $display("%0t: response beat with none expected, actual %0h", $time, got);
            mismatches++;
         end else begin
            want = pending_outputs.pop_front();
            check_field("duty_out", want.duty_out, got.duty_out);
            check_field("phase_out", want.phase_out, got.phase_out);
            check_field("decay_out", want.decay_out, got.decay_out);
            check_field("reset_pulse", want.reset_pulse, got.reset_pulse);
            check_field("done_res", want.done_res, got.done_res);
            check_field("fault_total", want.fault_total, got.fault_total);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      dir_row_type rows[$];
      csr_set_type sets[$];
      rsp_payload_type none;
      csr_set_type cs;
      none = '0;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      reset = 1'b1;

      set_volt    = SET_VOLTAGE_RST;
      seek_duty   = SEEK_DUTY_RST;
      coast_ticks = COAST_TICKS_RST;
      motor_mode  = MODE_BRAKE;
      coast_timer = '0;
      fault_count = '0;
      duty_q      = '0;
      phase_q     = 1'b0;
      decay_q     = 1'b0;

      // Directed table: item, typed expectation flag, typed expectation
      rows.push_back('{mk_req(FUNC_TICK, CMD_IDLE, 16'h0, 16'h0, 1, 1, 1, 1),
                       1'b1, mk_rsp(16'h0, 0, 0, 0, 0, 16'h0)});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_IDLE, 16'h0, 16'h0, 1, 1, 1, 1),
                       1'b1, mk_rsp(16'h0, 0, 0, 0, 1, 16'h0)});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_CW, 16'hFFFF, 16'd2400, 1, 1, 1, 1),
                       1'b1, mk_rsp(16'hFFFF, 1, 0, 0, 0, 16'h0)});
      // scaled at the top supply, with a fault
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_CCW, 16'hFFFF, 16'hFFFF, 1, 1, 1, 0),
                       1'b0, none});
      // zero duty ignores the fault input
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_CW, 16'h0, 16'h0, 1, 1, 1, 0),
                       1'b0, none});
      // stop while running, then while coasting, unknown codes as idle
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_IDLE, 16'h1, 16'h1, 0, 0, 0, 0),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, 3'd7, 16'h0, 16'h0, 1, 1, 1, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, 3'd6, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0),
                       1'b0, none});
      // seeks: reached, not reached with zero seek duty, reached
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_SEEK_MIN, 16'h0, 16'h0, 0, 1, 1, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_SEEK_MID, 16'h0, 16'h0, 0, 1, 0, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_SEEK_MAX, 16'hFFFF, 16'h0, 0, 0, 0, 0),
                       1'b0, none});
      // rounding: remainder exactly half, just over half
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_CW, 16'd1, 16'd4800, 1, 1, 1, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_CW, 16'd1, 16'd4705, 1, 1, 1, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_CCW, 16'd41, 16'd4800, 1, 1, 1, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_CW, 16'h8000, 16'h0, 1, 1, 1, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_SEEK_MIN, 16'h0, 16'h0, 1, 0, 0, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_IDLE, 16'h0, 16'h0, 1, 1, 1, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_TICK, CMD_CCW, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_CCW, 16'hFFFF, 16'd2401, 1, 1, 1, 0),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_SEEK_MID, 16'h0, 16'h0, 1, 0, 1, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_SEEK_MAX, 16'h0, 16'h0, 0, 0, 1, 1),
                       1'b0, none});
      rows.push_back('{mk_req(FUNC_COMMAND, CMD_IDLE, 16'h0, 16'h0, 1, 1, 1, 1),
                       1'b0, none});

      // Register settings for the random part, extremes first
      sets.push_back('{volt: 16'h0, seek: 16'h0, coast: 16'h0});
      sets.push_back('{volt: 16'hFFFF, seek: 16'hFFFF, coast: 16'hFFFF});
      sets.push_back('{volt: 16'd2400, seek: 16'h0800, coast: 16'd3});
      repeat (3) begin
         cs.volt  = VOLT_BITS'($urandom_range(500, 9000));
         cs.seek  = DUTY_BITS'($urandom_range(0, 65535));
         cs.coast = TICK_BITS'($urandom_range(0, 6));
         sets.push_back(cs);
      end

      // Reset
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_req(rows[i].item, rows[i].typed, rows[i].want);
      settle();

      // Bursts: back-to-back faulted runs, then back-to-back ticks
      write_csr(CSR_SEEK_DUTY, 16'h1234);
      write_csr(CSR_COAST_TICKS, 16'hFFFF);
      no_idle = 1'b1;
      repeat (BURST_ITEMS)
         send_req(mk_req(FUNC_COMMAND, CMD_CW, 16'h00FF, 16'd1000, 1, 1, 1, 0), 1'b0, none);
      send_req(mk_req(FUNC_COMMAND, CMD_IDLE, 16'h0, 16'h0, 1, 1, 1, 1), 1'b0, none);
      repeat (BURST_ITEMS)
         send_req(mk_req(FUNC_TICK, CMD_IDLE, 16'h0, 16'h0, 1, 1, 1, 1), 1'b0, none);
      send_req(mk_req(FUNC_COMMAND, CMD_IDLE, 16'h0, 16'h0, 1, 1, 1, 1), 1'b0, none);
      no_idle = 1'b0;
      settle();

      // Random commands under each register setting
      foreach (sets[s]) begin
         write_csr(CSR_SET_VOLTAGE, sets[s].volt);
         write_csr(CSR_SEEK_DUTY, sets[s].seek);
         write_csr(CSR_COAST_TICKS, sets[s].coast);
         if (s == 0) write_csr(CSR_UNUSED, CSR_DATA_BITS'($urandom_range(0, 65535)));
         repeat (ITEMS_PER_SET) send_req(random_item(), 1'b0, none);
         settle();
      end

      if (mismatches == 0 && pending_outputs.size() == 0) begin
         $display("PASS");
      end else begin
         if (pending_outputs.size() != 0)
            $display("%0t: %0d expected responses never arrived", $time,
                     pending_outputs.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
